### src/nurbs_curve_point_evaluator_unit_assert.svh
// Assertion macros for the curve point evaluator checker.
`ifndef NURBS_CURVE_POINT_EVALUATOR_UNIT_ASSERT_SVH
`define NURBS_CURVE_POINT_EVALUATOR_UNIT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define NCPE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("curve evaluator check failed");

// Consequence must hold in the cycle after the antecedent.
`define NCPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("curve evaluator check failed");

`endif

### src/ncpe_pkg.sv
// Shared constants and codes of the curve point evaluator.
`default_nettype none
package ncpe_pkg;
   localparam int COORD_W = 32;
   localparam int WEIGHT_W = 24;
   localparam int PARAM_W = 17;
   localparam int INDEX_W = 4;
   localparam int DEGREE_W = 3;
   localparam int COUNT_W = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int POINT_W = 3 * COORD_W + WEIGHT_W;

   localparam int DEF_MAX_POINTS = 16;
   localparam int DEF_MAX_DEGREE = 7;
   localparam int DEF_FRAC_BITS = 16;

   localparam logic [DEGREE_W-1:0] RESET_DEGREE = 3'd3;
   localparam logic [COUNT_W-1:0] RESET_COUNT = 5'd11;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEGREE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT = 2'd1;

   localparam logic [PARAM_W-1:0] PARAM_ONE = 17'd65536;
endpackage
`default_nettype wire

### src/ncpe_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ncpe_ram #(
   parameter int WIDTH = ncpe_pkg::POINT_W,
   parameter int DEPTH = ncpe_pkg::DEF_MAX_POINTS
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### src/nurbs_curve_point_evaluator_unit.sv
// Top level of the rational B-spline curve point evaluator.
`default_nettype none
// A write item (req_operation low) stores one control point and its weight in the
// point memory in the cycle it is accepted and gives no result; the unit stays ready.
// An evaluate item returns one point on the clamped uniform curve of the degree and
// point count held in the configuration registers. A parameter of one or more passes
// through ST_LAST_WAIT and ST_LAST_OUT and returns the last control point in use.
// Any other parameter runs the basis recursion and the weighted average on one shared
// divider that retires one quotient bit per cycle over a word of DDW bits (62 at the
// default parameters): every basis step between distinct knots costs two divisions,
// a step over coincident knots needs no division, there are p * (p + 1) / 2 steps for
// degree p, each of the p + 1 weighted points passes through the memory and the
// multipliers, and the three coordinates cost one division each. The result appears
// on the rsp_ ports for exactly one cycle, marked by rsp_valid, and the receiver
// cannot stall it, so it must take it then. When the weighted basis sum is zero the
// point is zero and rsp_degenerate is set, and the three final divisions are skipped.
// Points never written read as undefined data. Configuration may be written only
// while busy is low and no result is pending.
module nurbs_curve_point_evaluator_unit #(
   parameter int MAX_POINTS = ncpe_pkg::DEF_MAX_POINTS,
   parameter int MAX_DEGREE = ncpe_pkg::DEF_MAX_DEGREE,
   parameter int FRAC_BITS = ncpe_pkg::DEF_FRAC_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic                                  req_operation,
   input  wire logic [ncpe_pkg::INDEX_W-1:0]          req_point_index,
   input  wire logic signed [ncpe_pkg::COORD_W-1:0]   req_coord_x,
   input  wire logic signed [ncpe_pkg::COORD_W-1:0]   req_coord_y,
   input  wire logic signed [ncpe_pkg::COORD_W-1:0]   req_coord_z,
   input  wire logic [ncpe_pkg::WEIGHT_W-1:0]         req_point_weight,
   input  wire logic [ncpe_pkg::PARAM_W-1:0]          req_curve_param,
   output logic                                       rsp_valid,
   output logic signed [ncpe_pkg::COORD_W-1:0]        rsp_point_x,
   output logic signed [ncpe_pkg::COORD_W-1:0]        rsp_point_y,
   output logic signed [ncpe_pkg::COORD_W-1:0]        rsp_point_z,
   output logic                                       rsp_degenerate,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ncpe_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [ncpe_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   localparam int F = FRAC_BITS;
   localparam int CRW = ncpe_pkg::COORD_W;
   localparam int WTW = ncpe_pkg::WEIGHT_W;
   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int DW = $clog2(MAX_DEGREE + 1);
   localparam int KW = $clog2(MAX_POINTS + 2 * MAX_DEGREE + 2) + 1;
   localparam int SW = F + NW;
   localparam int NBW = F + 1;
   localparam int PRW = SW + NBW;
   localparam int CW = WTW + 1;
   localparam int TW = $clog2(MAX_DEGREE + 2);
   localparam int WSW = CW + TW;
   localparam int MW = CW + 1 + CRW;
   localparam int NUMW = MW + TW;
   localparam int DDW = (PRW > NUMW) ? PRW : NUMW;
   localparam int DVW = (SW > WSW) ? SW : WSW;
   localparam int CNTW = $clog2(DDW);
   localparam int SH_UP = (F >= 16) ? (F - 16) : 0;
   localparam int SH_DN = (F >= 16) ? 0 : (16 - F);
   localparam int X_HI = ncpe_pkg::POINT_W - 1;
   localparam int Y_HI = X_HI - CRW;
   localparam int Z_HI = Y_HI - CRW;
   localparam int W_HI = Z_HI - CRW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LAST_WAIT, ST_LAST_OUT, ST_B_STEP, ST_DIV, ST_B_MULL, ST_B_UPD,
      ST_W_ADDR, ST_W_WAIT, ST_W_DATA, ST_W_PROD, ST_W_ACC, ST_F_SETUP, ST_F_DONE
   } state_type;

   state_type state_ff, div_ret_ff;

   logic [ncpe_pkg::DEGREE_W-1:0] degree_ff;
   logic [ncpe_pkg::COUNT_W-1:0] count_ff;

   logic [SW-1:0] s_ff, left_ff;
   logic [KW-1:0] k_ff;
   logic [NW-1:0] n_ff;
   logic [DW-1:0] p_ff, j_ff, r_ff;
   logic [1:0] axis_ff;
   logic [NBW-1:0] nb_ff [0:MAX_DEGREE];
   logic [NBW-1:0] saved_ff, cur_ff, q1_ff;
   logic [CW-1:0] c_ff;
   logic signed [MW-1:0] px_ff, py_ff, pz_ff;
   logic signed [NUMW-1:0] num_x_ff, num_y_ff, num_z_ff;
   logic [WSW-1:0] wsum_ff;
   logic neg_ff;
   logic [AW-1:0] rd_addr_ff;
   logic [DDW-1:0] div_quo_ff;
   logic [DVW-1:0] div_den_ff, div_rem_ff;
   logic [CNTW-1:0] div_cnt_ff;
   logic rsp_valid_ff, rsp_degenerate_ff;
   logic signed [CRW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;

   // Point memory: {x, y, z, weight} per entry.
   logic ram_we;
   logic [AW-1:0] ram_wr_addr;
   logic [ncpe_pkg::POINT_W-1:0] ram_rd;
   logic [31:0] wr_index_wide;

   assign wr_index_wide = 32'(req_point_index);
   assign ram_wr_addr = wr_index_wide[AW-1:0];
   assign ram_we = start && !busy && (req_operation == ncpe_pkg::OP_WRITE) &&
                   (wr_index_wide < 32'(MAX_POINTS));

   ncpe_ram #(
      .WIDTH(ncpe_pkg::POINT_W),
      .DEPTH(MAX_POINTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_coord_x, req_coord_y, req_coord_z, req_point_weight}),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd)
   );

   logic signed [CRW-1:0] rd_x, rd_y, rd_z;
   logic [WTW-1:0] rd_w;
   assign rd_x = $signed(ram_rd[X_HI -: CRW]);
   assign rd_y = $signed(ram_rd[Y_HI -: CRW]);
   assign rd_z = $signed(ram_rd[Z_HI -: CRW]);
   assign rd_w = ram_rd[W_HI -: WTW];

   // Effective point count and degree after clamping.
   int n_i, p_i;
   always_comb begin
      n_i = int'(count_ff);
      if (n_i < 2) n_i = 2;
      if (n_i > MAX_POINTS) n_i = MAX_POINTS;
      p_i = int'(degree_ff);
      if (p_i < 1) p_i = 1;
      if (p_i > MAX_DEGREE) p_i = MAX_DEGREE;
      if (p_i > n_i - 1) p_i = n_i - 1;
   end

   logic [NW-1:0] n_acc, nmp_acc;
   logic [DW-1:0] p_acc;
   logic [AW-1:0] last_addr;
   logic is_last;
   logic [F+16:0] t_big, t_scaled;
   logic [F-1:0] tf;
   logic [SW-1:0] s_acc;
   logic [KW-1:0] k_acc;

   assign n_acc = NW'(n_i);
   assign p_acc = DW'(p_i);
   assign nmp_acc = NW'(n_i - p_i);
   assign last_addr = AW'(n_i - 1);
   assign is_last = req_curve_param >= ncpe_pkg::PARAM_ONE;
   assign t_big = (F + 17)'(req_curve_param[15:0]);
   assign t_scaled = (F >= 16) ? (t_big << SH_UP) : (t_big >> SH_DN);
   assign tf = t_scaled[F-1:0];
   // Scaling by the span count makes every knot an integer in fixed point.
   assign s_acc = SW'(tf) * SW'(nmp_acc);
   assign k_acc = KW'(p_acc) + KW'(s_acc >> F);

   function automatic logic [NW-1:0] knot_at(input logic [KW-1:0] jj,
                                             input logic [DW-1:0] pp,
                                             input logic [NW-1:0] nn);
      logic [NW-1:0] v;
      if (jj <= KW'(pp)) v = '0;
      else if (jj >= KW'(nn)) v = nn - NW'(pp);
      else v = NW'(jj - KW'(pp));
      return v;
   endfunction

   // Basis step operands: the knot gaps around the span.
   logic [KW-1:0] hi_idx, lo_idx, w_idx;
   logic [NW-1:0] hi_kn, lo_kn;
   logic [SW-1:0] hi_fx, lo_fx, right_v, left_v, gap_v;
   logic [NBW-1:0] nb_cur;
   logic inner_last, outer_last;

   assign hi_idx = k_ff + KW'(r_ff) + KW'(1);
   assign lo_idx = k_ff + KW'(1) - KW'(j_ff) + KW'(r_ff);
   assign hi_kn = knot_at(hi_idx, p_ff, n_ff);
   assign lo_kn = knot_at(lo_idx, p_ff, n_ff);
   assign hi_fx = SW'(hi_kn) << F;
   assign lo_fx = SW'(lo_kn) << F;
   assign right_v = hi_fx - s_ff;
   assign left_v = s_ff - lo_fx;
   assign gap_v = hi_fx - lo_fx;
   assign nb_cur = nb_ff[r_ff];
   assign inner_last = (r_ff == j_ff - DW'(1));
   assign outer_last = (j_ff == p_ff);
   assign w_idx = k_ff - KW'(p_ff) + KW'(r_ff);

   logic [NBW+WTW-1:0] wprod;
   assign wprod = (NBW + WTW)'(nb_cur) * (NBW + WTW)'(rd_w);

   logic [WSW-1:0] wsum_next;
   assign wsum_next = wsum_ff + WSW'(c_ff);

   // Restoring divider step.
   logic [DVW:0] div_shift, div_diff;
   logic div_bit;
   assign div_shift = {div_rem_ff, div_quo_ff[DDW-1]};
   assign div_diff = div_shift - {1'b0, div_den_ff};
   assign div_bit = div_shift >= {1'b0, div_den_ff};

   // Signed numerator selection and saturated quotient for the final average.
   logic signed [NUMW-1:0] num_sel;
   logic [NUMW-1:0] num_mag;
   logic signed [CRW-1:0] coord_res;
   logic [CRW-1:0] q_low;

   always_comb begin
      case (axis_ff)
         2'd0: num_sel = num_x_ff;
         2'd1: num_sel = num_y_ff;
         default: num_sel = num_z_ff;
      endcase
   end
   assign num_mag = num_sel[NUMW-1] ? NUMW'(-num_sel) : NUMW'(num_sel);
   assign q_low = div_quo_ff[CRW-1:0];

   always_comb begin
      if (!neg_ff) begin
         coord_res = (div_quo_ff > DDW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q_low);
      end else begin
         coord_res = (div_quo_ff >= DDW'(64'h8000_0000)) ? 32'sh8000_0000 :
                     $signed(~q_low + CRW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         div_ret_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         degree_ff <= ncpe_pkg::RESET_DEGREE;
         count_ff <= ncpe_pkg::RESET_COUNT;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ncpe_pkg::CSR_DEGREE: degree_ff <= csr_wdata[ncpe_pkg::DEGREE_W-1:0];
               ncpe_pkg::CSR_COUNT: count_ff <= csr_wdata[ncpe_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               // A result strobe is only raised on the way back to idle.
               rsp_valid_ff <= 1'b0;
               if (start && req_operation == ncpe_pkg::OP_EVAL) begin
                  n_ff <= n_acc;
                  p_ff <= p_acc;
                  s_ff <= s_acc;
                  k_ff <= k_acc;
                  j_ff <= DW'(1);
                  r_ff <= '0;
                  saved_ff <= '0;
                  nb_ff[0] <= NBW'(1) << F;
                  wsum_ff <= '0;
                  num_x_ff <= '0;
                  num_y_ff <= '0;
                  num_z_ff <= '0;
                  if (is_last) begin
                     rd_addr_ff <= last_addr;
                     state_ff <= ST_LAST_WAIT;
                  end else begin
                     state_ff <= ST_B_STEP;
                  end
               end
            end
            ST_LAST_WAIT: state_ff <= ST_LAST_OUT;
            ST_LAST_OUT: begin
               rsp_x_ff <= rd_x;
               rsp_y_ff <= rd_y;
               rsp_z_ff <= rd_z;
               rsp_degenerate_ff <= 1'b0;
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_B_STEP: begin
               cur_ff <= nb_cur;
               left_ff <= left_v;
               div_den_ff <= DVW'(gap_v);
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
               if (gap_v == '0) begin
                  // Coincident knots: this term contributes nothing.
                  q1_ff <= '0;
                  div_quo_ff <= '0;
                  state_ff <= ST_B_UPD;
               end else begin
                  div_quo_ff <= DDW'(PRW'(right_v) * PRW'(nb_cur));
                  div_ret_ff <= ST_B_MULL;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               div_rem_ff <= div_bit ? div_diff[DVW-1:0] : div_shift[DVW-1:0];
               div_quo_ff <= {div_quo_ff[DDW-2:0], div_bit};
               div_cnt_ff <= div_cnt_ff + CNTW'(1);
               if (div_cnt_ff == CNTW'(DDW - 1)) begin
                  state_ff <= div_ret_ff;
               end
            end
            ST_B_MULL: begin
               q1_ff <= div_quo_ff[NBW-1:0];
               div_quo_ff <= DDW'(PRW'(left_ff) * PRW'(cur_ff));
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
               div_ret_ff <= ST_B_UPD;
               state_ff <= ST_DIV;
            end
            ST_B_UPD: begin
               nb_ff[r_ff] <= saved_ff + q1_ff;
               if (inner_last) begin
                  nb_ff[j_ff] <= div_quo_ff[NBW-1:0];
                  saved_ff <= '0;
                  r_ff <= '0;
                  if (outer_last) begin
                     state_ff <= ST_W_ADDR;
                  end else begin
                     j_ff <= j_ff + DW'(1);
                     state_ff <= ST_B_STEP;
                  end
               end else begin
                  saved_ff <= div_quo_ff[NBW-1:0];
                  r_ff <= r_ff + DW'(1);
                  state_ff <= ST_B_STEP;
               end
            end
            ST_W_ADDR: begin
               rd_addr_ff <= w_idx[AW-1:0];
               state_ff <= ST_W_WAIT;
            end
            ST_W_WAIT: state_ff <= ST_W_DATA;
            ST_W_DATA: begin
               c_ff <= CW'(wprod >> F);
               state_ff <= ST_W_PROD;
            end
            ST_W_PROD: begin
               px_ff <= MW'($signed({1'b0, c_ff})) * MW'(rd_x);
               py_ff <= MW'($signed({1'b0, c_ff})) * MW'(rd_y);
               pz_ff <= MW'($signed({1'b0, c_ff})) * MW'(rd_z);
               state_ff <= ST_W_ACC;
            end
            ST_W_ACC: begin
               wsum_ff <= wsum_next;
               num_x_ff <= num_x_ff + NUMW'(px_ff);
               num_y_ff <= num_y_ff + NUMW'(py_ff);
               num_z_ff <= num_z_ff + NUMW'(pz_ff);
               if (r_ff == p_ff) begin
                  axis_ff <= 2'd0;
                  if (wsum_next == '0) begin
                     rsp_x_ff <= '0;
                     rsp_y_ff <= '0;
                     rsp_z_ff <= '0;
                     rsp_degenerate_ff <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_F_SETUP;
                  end
               end else begin
                  r_ff <= r_ff + DW'(1);
                  state_ff <= ST_W_ADDR;
               end
            end
            ST_F_SETUP: begin
               neg_ff <= num_sel[NUMW-1];
               div_quo_ff <= DDW'(num_mag);
               div_den_ff <= DVW'(wsum_ff);
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
               div_ret_ff <= ST_F_DONE;
               state_ff <= ST_DIV;
            end
            ST_F_DONE: begin
               case (axis_ff)
                  2'd0: rsp_x_ff <= coord_res;
                  2'd1: rsp_y_ff <= coord_res;
                  default: rsp_z_ff <= coord_res;
               endcase
               if (axis_ff == 2'd2) begin
                  rsp_degenerate_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  axis_ff <= axis_ff + 2'd1;
                  state_ff <= ST_F_SETUP;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;
   assign rsp_point_z = rsp_z_ff;
   assign rsp_degenerate = rsp_degenerate_ff;
endmodule
`default_nettype wire

### src/ncpe_checker.sv
// Port-level checks of the curve point evaluator, bound to its top level.
`default_nettype none
`include "nurbs_curve_point_evaluator_unit_assert.svh"
module ncpe_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic                                req_operation,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_degenerate,
   input wire logic signed [ncpe_pkg::COORD_W-1:0] rsp_point_x,
   input wire logic signed [ncpe_pkg::COORD_W-1:0] rsp_point_y,
   input wire logic signed [ncpe_pkg::COORD_W-1:0] rsp_point_z
);
   logic write_taken, eval_taken, degen_shown, point_zero;
   assign write_taken = start && !busy && req_operation == ncpe_pkg::OP_WRITE;
   assign eval_taken = start && !busy && req_operation == ncpe_pkg::OP_EVAL;
   assign degen_shown = rsp_valid && rsp_degenerate;
   assign point_zero = rsp_point_x == 0 && rsp_point_y == 0 && rsp_point_z == 0;

   // A result is only shown once the unit has gone back to idle.
   `NCPE_ASSERT_SAME(rsp_when_idle, clock, reset, rsp_valid, !busy)
   // The result strobe lasts one cycle.
   `NCPE_ASSERT_NEXT(rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // A write item gives no result.
   `NCPE_ASSERT_NEXT(write_silent, clock, reset, write_taken, !rsp_valid)
   // An evaluate item occupies the unit.
   `NCPE_ASSERT_NEXT(eval_busy, clock, reset, eval_taken, busy)
   // A degenerate result carries a zero point.
   `NCPE_ASSERT_SAME(degen_zero, clock, reset, degen_shown, point_zero)
endmodule

bind nurbs_curve_point_evaluator_unit ncpe_checker u_ncpe_checker (.*);
`default_nettype wire
